[hdl/aabbcr_pkg.sv]
// Shared types and constants for the rectangle collision resolve unit.
package aabbcr_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int POS_W           = 24;
  localparam int SUM_W           = 26;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  // Command codes of the input channel.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Register indexes of the configuration port.
  localparam int REG_PLAYER_KIND = 0;

  typedef struct packed {
    logic               command;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [3:0]         kind;
    logic               has_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic               hit;
    logic [3:0]         hit_kind;
    logic               last;
  } out_item_t;

  // One stored rectangle, including its hit record.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [3:0]         kind;
    logic               hv;
    logic               hit;
    logic [3:0]         hk;
  } entry_t;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_A,
    WSEL_B
  } wsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_RD,
    ST_P_OVL,
    ST_P_MX,
    ST_P_APPLY,
    ST_P_WA,
    ST_P_WB,
    ST_E_RD,
    ST_E_LD,
    ST_E_WAIT
  } state_t;

  typedef struct packed {
    logic  we;
    wsel_t wsel;
    logic  capture;
    logic  mx_en;
    logic  apply_en;
    logic  out_load;
    logic  out_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic ov;
  } dp_stat_t;

endpackage

[hdl/aabbcr_ram.sv]
// Generic RAM with one write port and two registered read ports.
module aabbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

[hdl/aabbcr_ctrl.sv]
// Controller: load handling, pair walk and result emission sequencing.
module aabbcr_ctrl
  import aabbcr_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_command,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ctl_cmd_t      cmd,
  input  dp_stat_t      stat,
  output logic [AW-1:0] wr_addr,
  output logic [AW-1:0] rd_a_addr,
  output logic [AW-1:0] rd_b_addr
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          in_acc;
  logic          adv;
  logic          pairs_done;
  logic          last_res;
  logic          full;

  assign in_acc     = in_valid && (state_r == ST_IDLE);
  assign full       = (count_r >= CW'(MAX_ENTRIES));
  assign pairs_done = (j_r == count_r - CW'(1)) && (i_r + CW'(2) >= count_r);
  assign last_res   = (k_r == count_r - CW'(1));
  assign adv        = ((state_r == ST_P_MX) && !stat.ov) || (state_r == ST_P_WB);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_command == CMD_RUN)) begin
          if (count_r == CW'(0)) begin
            state_nxt = ST_IDLE;
          end else if (count_r == CW'(1)) begin
            state_nxt = ST_E_RD;
          end else begin
            state_nxt = ST_P_RD;
          end
        end
      end
      ST_P_RD:    state_nxt = ST_P_OVL;
      ST_P_OVL:   state_nxt = ST_P_MX;
      ST_P_MX: begin
        if (stat.ov) begin
          state_nxt = ST_P_APPLY;
        end else begin
          state_nxt = pairs_done ? ST_E_RD : ST_P_RD;
        end
      end
      ST_P_APPLY: state_nxt = ST_P_WA;
      ST_P_WA:    state_nxt = ST_P_WB;
      ST_P_WB:    state_nxt = pairs_done ? ST_E_RD : ST_P_RD;
      ST_E_RD:    state_nxt = ST_E_LD;
      ST_E_LD:    state_nxt = ST_E_WAIT;
      ST_E_WAIT: begin
        if (!out_stall) begin
          state_nxt = last_res ? ST_IDLE : ST_E_RD;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    cmd       = '0;
    cmd.wsel  = WSEL_LOAD;
    wr_addr   = count_r[AW-1:0];
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc && (in_command == CMD_LOAD) && !full) begin
          cmd.we = 1'b1;
        end
      end
      ST_P_OVL:   cmd.capture = 1'b1;
      ST_P_MX:    cmd.mx_en = 1'b1;
      ST_P_APPLY: cmd.apply_en = 1'b1;
      ST_P_WA: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_A;
        wr_addr  = i_r[AW-1:0];
      end
      ST_P_WB: begin
        cmd.we   = 1'b1;
        cmd.wsel = WSEL_B;
        wr_addr  = j_r[AW-1:0];
      end
      ST_E_LD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = last_res;
      end
      ST_E_WAIT:  out_valid = 1'b1;
      default:    cmd = '0;
    endcase
  end

  assign rd_a_addr = (state_r == ST_E_RD) ? k_r[AW-1:0] : i_r[AW-1:0];
  assign rd_b_addr = j_r[AW-1:0];

  // Entry count and pair and result indexes.
  always_comb begin
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    if (in_acc && (in_command == CMD_LOAD) && !full) begin
      count_nxt = count_r + CW'(1);
    end
    if (in_acc && (in_command == CMD_RUN)) begin
      i_nxt = '0;
      j_nxt = CW'(1);
      k_nxt = '0;
    end
    if (adv && !pairs_done) begin
      if (j_r == count_r - CW'(1)) begin
        i_nxt = i_r + CW'(1);
        j_nxt = i_r + CW'(2);
      end else begin
        j_nxt = j_r + CW'(1);
      end
    end
    if ((state_r == ST_E_WAIT) && !out_stall && !last_res) begin
      k_nxt = k_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

[hdl/aabbcr_dpath.sv]
// Datapath: rectangle store, overlap test, push-out and result register.
module aabbcr_dpath
  import aabbcr_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES)
) (
  input  logic          clk,
  input  in_item_t      in_data,
  input  logic [3:0]    player_kind,
  input  ctl_cmd_t      cmd,
  output dp_stat_t      stat,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output out_item_t     out_data
);

  entry_t ld_entry, wr_data, rd_a, rd_b;
  entry_t ea_r, ea_nxt, eb_r, eb_nxt;
  entry_t p_e, o_e, p_new;
  logic   ov_r, ov_nxt, ovl_c;
  logic   pa_r, pa_nxt, do_r, do_nxt;
  logic signed [SUM_W-1:0] mx_r, mx_nxt, my_r, my_nxt;
  logic signed [SUM_W-1:0] ol, orr, ot, ob;
  logic [SUM_W-1:0] abs_mx, abs_my;
  logic signed [SUM_W:0] sum_c;
  logic signed [POS_W-1:0] sat_c;
  logic   x_axis;
  out_item_t out_r, out_nxt;

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [POS_W-1:0] v);
    return SUM_W'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] zx(input logic [15:0] v);
    return $signed({{(SUM_W-16){1'b0}}, v});
  endfunction

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // Load word: a freshly loaded rectangle has no hit record.
  always_comb begin
    ld_entry.x    = in_data.pos_x;
    ld_entry.y    = in_data.pos_y;
    ld_entry.w    = in_data.width;
    ld_entry.h    = in_data.height;
    ld_entry.vx   = in_data.vel_x;
    ld_entry.vy   = in_data.vel_y;
    ld_entry.kind = in_data.kind;
    ld_entry.hv   = in_data.has_velocity;
    ld_entry.hit  = 1'b0;
    ld_entry.hk   = '0;
  end

  always_comb begin
    case (cmd.wsel)
      WSEL_A:  wr_data = ea_r;
      WSEL_B:  wr_data = eb_r;
      default: wr_data = ld_entry;
    endcase
  end

  aabbcr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk       (clk),
    .we        (cmd.we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a),
    .rd_b_data (rd_b)
  );

  // Strict overlap of the two rectangles just read.
  assign ovl_c = (sx(rd_a.x) < sx(rd_b.x) + zx(rd_b.w)) &&
                 (sx(rd_a.x) + zx(rd_a.w) > sx(rd_b.x)) &&
                 (sx(rd_a.y) < sx(rd_b.y) + zx(rd_b.h)) &&
                 (sx(rd_a.y) + zx(rd_a.h) > sx(rd_b.y));

  // Pushed and other rectangle of the pair.
  assign p_e = pa_r ? ea_r : eb_r;
  assign o_e = pa_r ? eb_r : ea_r;

  // Signed overlaps on both sides of each axis.
  always_comb begin
    ol  = sx(o_e.x) + zx(o_e.w) - sx(p_e.x);
    orr = sx(p_e.x) + zx(p_e.w) - sx(o_e.x);
    ot  = sx(o_e.y) + zx(o_e.h) - sx(p_e.y);
    ob  = sx(p_e.y) + zx(p_e.h) - sx(o_e.y);
  end

  // Push along the axis of smaller overlap, ties to Y, with saturation.
  always_comb begin
    abs_mx = mag(mx_r);
    abs_my = mag(my_r);
    x_axis = abs_mx < abs_my;
    p_new  = p_e;
    if (x_axis) begin
      sum_c = (SUM_W+1)'(p_e.x) + (SUM_W+1)'(mx_r);
    end else begin
      sum_c = (SUM_W+1)'(p_e.y) + (SUM_W+1)'(my_r);
    end
    if (sum_c > (SUM_W+1)'(POS_MAX)) begin
      sat_c = POS_MAX;
    end else if (sum_c < (SUM_W+1)'(POS_MIN)) begin
      sat_c = POS_MIN;
    end else begin
      sat_c = sum_c[POS_W-1:0];
    end
    if (x_axis) begin
      p_new.x = sat_c;
      if ((mx_r < 0 && p_e.vx > 0) || (mx_r > 0 && p_e.vx < 0)) begin
        p_new.vx = '0;
      end
    end else begin
      p_new.y = sat_c;
      if ((my_r < 0 && p_e.vy > 0) || (my_r > 0 && p_e.vy < 0)) begin
        p_new.vy = '0;
      end
    end
  end

  // Pair registers, one step per command.
  always_comb begin
    ea_nxt = ea_r;
    eb_nxt = eb_r;
    ov_nxt = ov_r;
    pa_nxt = pa_r;
    do_nxt = do_r;
    mx_nxt = mx_r;
    my_nxt = my_r;
    if (cmd.capture) begin
      ea_nxt = rd_a;
      eb_nxt = rd_b;
      ov_nxt = ovl_c;
      pa_nxt = (rd_a.kind == player_kind);
      do_nxt = (rd_a.kind == player_kind) ? rd_a.hv
                                          : ((rd_b.kind == player_kind) && rd_b.hv);
    end
    if (cmd.mx_en) begin
      if (ov_r) begin
        ea_nxt.hit = 1'b1;
        ea_nxt.hk  = eb_r.kind;
        eb_nxt.hit = 1'b1;
        eb_nxt.hk  = ea_r.kind;
      end
      mx_nxt = (mag(ol) < mag(orr)) ? ol : -orr;
      my_nxt = (mag(ot) < mag(ob)) ? ot : -ob;
    end
    if (cmd.apply_en && do_r) begin
      if (pa_r) begin
        ea_nxt = p_new;
      end else begin
        eb_nxt = p_new;
      end
    end
  end

  // Result register.
  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      out_nxt.new_x     = rd_a.x;
      out_nxt.new_y     = rd_a.y;
      out_nxt.new_vel_x = rd_a.vx;
      out_nxt.new_vel_y = rd_a.vy;
      out_nxt.hit       = rd_a.hit;
      out_nxt.hit_kind  = rd_a.hit ? rd_a.hk : 4'd0;
      out_nxt.last      = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    ea_r  <= ea_nxt;
    eb_r  <= eb_nxt;
    ov_r  <= ov_nxt;
    pa_r  <= pa_nxt;
    do_r  <= do_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    out_r <= out_nxt;
  end

  assign stat.ov  = ov_r;
  assign out_data = out_r;

endmodule

[hdl/aabb_pairwise_collision_resolve_unit.sv]
// Top level of the pairwise rectangle collision resolve unit.
// Up to MAX_ENTRIES rectangles are kept; further loads are accepted but dropped.
// A run walks all pairs in load order: each pair is read, tested for overlap
// and given its push offsets; an overlapping pair adds the push and two store writes.
// Each result is then read, registered and held while the result side stalls.
// Reset clears the controller, the entry count and player_kind; store contents stay.
module aabb_pairwise_collision_resolve_unit
  import aabbcr_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [3:0]    player_kind_r, player_kind_nxt;
  logic          reg_sel;
  ctl_cmd_t      cmd;
  dp_stat_t      stat;
  logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

  // Configuration register on the APB port.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_AW-1:2] == (CFG_AW-2)'(REG_PLAYER_KIND));
  assign prdata  = reg_sel ? {{(CFG_DW-4){1'b0}}, player_kind_r} : '0;

  always_comb begin
    player_kind_nxt = player_kind_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      player_kind_nxt = pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_kind_r <= '0;
    end else begin
      player_kind_r <= player_kind_nxt;
    end
  end

  aabbcr_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat),
    .wr_addr    (wr_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr)
  );

  aabbcr_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .in_data     (in_data),
    .player_kind (player_kind_r),
    .cmd         (cmd),
    .stat        (stat),
    .wr_addr     (wr_addr),
    .rd_a_addr   (rd_a_addr),
    .rd_b_addr   (rd_b_addr),
    .out_data    (out_data)
  );

  // The block never offers a result while it takes input.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result offered while input is taken");

  // A load write only comes from an accepted load transaction.
  a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.we && cmd.wsel == WSEL_LOAD) |-> (in_valid && !in_stall && !in_data.command))
    else $error("store load write without load transaction");

  // Loading the result register presents it in the next cycle.
  a_out_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result register loaded but not presented");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the pairwise rectangle collision resolve unit.
`timescale 1ns / 100ps

module testbench
  import aabbcr_pkg::*;
;

  localparam int CAP = MAX_ENTRIES_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  aabb_pairwise_collision_resolve_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the rectangle store.
  longint sx[CAP], sy[CAP], sw[CAP], sh[CAP], svx[CAP], svy[CAP];
  logic [3:0] skind[CAP], shk[CAP];
  bit shv[CAP], shit[CAP];
  int count;
  logic [3:0] pk;

  out_item_t pending_rects[$];
  int errors = 0;
  int dir_errors;
  int idle_cycles;
  bit stop_idle;

  // Directed stimulus: item and the result typed in where obvious.
  typedef struct {
    in_item_t item;
    bit has_exp;
    out_item_t exp;
  } row_t;
  row_t rows[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp24(longint v);
    if (v < -8388608) return -8388608;
    if (v > 8388607) return 8388607;
    return v;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit rects_touch(int a, int b);
    return sx[a] < sx[b] + sw[b] && sx[a] + sw[a] > sx[b] &&
           sy[a] < sy[b] + sh[b] && sy[a] + sh[a] > sy[b];
  endfunction

  // Pushes rectangle p out of rectangle o along the shallower axis.
  function automatic void separate(int p, int o);
    longint ol, orr, ot, ob, mx, my;
    ol = sx[o] + sw[o] - sx[p];
    orr = sx[p] + sw[p] - sx[o];
    ot = sy[o] + sh[o] - sy[p];
    ob = sy[p] + sh[p] - sy[o];
    mx = (absl(ol) < absl(orr)) ? ol : -orr;
    my = (absl(ot) < absl(ob)) ? ot : -ob;
    if (absl(mx) < absl(my)) begin
      sx[p] = clamp24(sx[p] + mx);
      if ((mx < 0 && svx[p] > 0) || (mx > 0 && svx[p] < 0)) svx[p] = 0;
    end else begin
      sy[p] = clamp24(sy[p] + my);
      if ((my < 0 && svy[p] > 0) || (my > 0 && svy[p] < 0)) svy[p] = 0;
    end
  endfunction

  // Applies one accepted transaction to the shadow store.
  function automatic void resolve_item(in_item_t it);
    out_item_t r;
    if (it.command == CMD_LOAD) begin
      if (count < CAP) begin
        sx[count] = longint'(it.pos_x);
        sy[count] = longint'(it.pos_y);
        sw[count] = longint'(it.width);
        sh[count] = longint'(it.height);
        svx[count] = longint'(it.vel_x);
        svy[count] = longint'(it.vel_y);
        skind[count] = it.kind;
        shv[count] = it.has_velocity;
        shit[count] = 1'b0;
        shk[count] = '0;
        count++;
      end
      return;
    end
    for (int i = 0; i < count; i++)
      for (int j = i + 1; j < count; j++) begin
        if (!rects_touch(i, j)) continue;
        shit[i] = 1; shk[i] = skind[j];
        shit[j] = 1; shk[j] = skind[i];
        if (skind[i] == pk) begin
          if (shv[i]) separate(i, j);
        end else if (skind[j] == pk) begin
          if (shv[j]) separate(j, i);
        end
      end
    for (int i = 0; i < count; i++) begin
      r.new_x = sx[i][23:0];
      r.new_y = sy[i][23:0];
      r.new_vel_x = svx[i][15:0];
      r.new_vel_y = svy[i][15:0];
      r.hit = shit[i];
      r.hit_kind = shit[i] ? shk[i] : 4'd0;
      r.last = (i + 1 == count);
      pending_rects.push_back(r);
    end
  endfunction

  function automatic in_item_t load_item(int x, int y, int w, int h, int vx, int vy,
                                         int k, bit hv);
    in_item_t it;
    it.command = CMD_LOAD;
    it.pos_x = 24'(x); it.pos_y = 24'(y); it.width = 16'(w); it.height = 16'(h);
    it.vel_x = 16'(vx); it.vel_y = 16'(vy); it.kind = 4'(k); it.has_velocity = hv;
    return it;
  endfunction

  function automatic in_item_t run_item();
    in_item_t it;
    it = '0;
    it.command = CMD_RUN;
    return it;
  endfunction

  // Random rectangle, mostly clustered so that pairs overlap.
  function automatic in_item_t rand_load();
    in_item_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.vel_x = 16'($urandom);
    it.vel_y = 16'($urandom);
    it.has_velocity = 1'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        it.pos_x = 24'($urandom); it.pos_y = 24'($urandom);
        it.width = 16'($urandom); it.height = 16'($urandom);
      end
      1: begin
        it.pos_x = $urandom_range(0, 1) ? 24'(24'h7FFF00 + $urandom_range(0, 255))
                                        : 24'(24'h800000 + $urandom_range(0, 255));
        it.pos_y = $urandom_range(0, 1) ? 24'h7FFF00 : 24'h800000;
        it.width = 16'($urandom); it.height = 16'($urandom);
      end
      default: begin
        it.pos_x = 24'(int'($urandom_range(0, 8000)) - 4000);
        it.pos_y = 24'(int'($urandom_range(0, 8000)) - 4000);
        it.width = 16'($urandom_range(0, 3000));
        it.height = 16'($urandom_range(0, 3000));
      end
    endcase
    it.kind = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    return it;
  endfunction

  // Sends one transaction, with an optional random gap beforehand.
  task automatic send_item(in_item_t it, bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    resolve_item(it);
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rects.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_player_kind(logic [3:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * REG_PLAYER_KIND); pwdata <= {28'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pk = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker with random back pressure.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rects.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pending_rects.pop_front();
        if (out_data.new_x !== want.new_x)
          $display("%0t: new_x expected %h actual %h", $time, want.new_x, out_data.new_x);
        if (out_data.new_y !== want.new_y)
          $display("%0t: new_y expected %h actual %h", $time, want.new_y, out_data.new_y);
        if (out_data.new_vel_x !== want.new_vel_x)
          $display("%0t: new_vel_x expected %h actual %h", $time, want.new_vel_x,
                   out_data.new_vel_x);
        if (out_data.new_vel_y !== want.new_vel_y)
          $display("%0t: new_vel_y expected %h actual %h", $time, want.new_vel_y,
                   out_data.new_vel_y);
        if (out_data.hit !== want.hit)
          $display("%0t: hit expected %b actual %b", $time, want.hit, out_data.hit);
        if (out_data.hit_kind !== want.hit_kind)
          $display("%0t: hit_kind expected %h actual %h", $time, want.hit_kind,
                   out_data.hit_kind);
        if (out_data.last !== want.last)
          $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
        if (out_data !== want) errors++;
      end
    end
    if (!rst_n || stop_idle) out_stall <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 3) == 0) out_stall <= 1'b0;
    else if (!out_stall) out_stall <= ($urandom_range(0, 4) == 0);
  end

  // Watchdog on cycles in which no transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    row_t rw;
    out_item_t e;
    int runs;
    dir_errors = 0; count = 0; pk = 0; stop_idle = 0;
    rst_n = 0; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store run gives nothing; then a lone rectangle at the extremes.
    rw.item = run_item(); rw.has_exp = 0; rows.push_back(rw);
    rw.item = load_item(-8388608, 8388607, 16'hFFFF, 0, -32768, 32767, 15, 1);
    rw.has_exp = 0; rows.push_back(rw);
    rw.item = run_item(); rw.item.pos_x = 24'h123456; rw.item.kind = 4'hA;
    rw.has_exp = 1;
    e.new_x = -24'sh800000; e.new_y = 24'sh7FFFFF; e.new_vel_x = -16'sh8000;
    e.new_vel_y = 16'sh7FFF; e.hit = 0; e.hit_kind = 0; e.last = 1;
    rw.exp = e; rows.push_back(rw);
    // Player against a wall: X push, Y push, tie to Y, no velocity, saturation.
    rw.has_exp = 0;
    rw.item = load_item(0, 0, 1000, 1000, 5, 5, 0, 1); rows.push_back(rw);
    rw.item = load_item(900, 200, 1000, 100, -5, 0, 3, 1); rows.push_back(rw);
    rw.item = load_item(100, 100, 500, 500, 0, 0, 4, 0); rows.push_back(rw);
    rw.item = load_item(-100, -100, 200, 200, 7, 7, 0, 1); rows.push_back(rw);
    rw.item = load_item(8388000, 8388000, 16'hFFFF, 16'hFFFF, 1, 1, 0, 1);
    rows.push_back(rw);
    rw.item = load_item(8388100, 8388300, 100, 100, 0, 0, 2, 0); rows.push_back(rw);
    rw.item = load_item(-8388608, -8388608, 16'hFFFF, 16'hFFFF, -1, -1, 0, 1);
    rows.push_back(rw);
    rw.item = load_item(-8388600, -8388600, 10, 10, 0, 0, 9, 1); rows.push_back(rw);
    rw.item = run_item(); rows.push_back(rw);
    rw.item = run_item(); rows.push_back(rw);

    foreach (rows[k]) begin
      send_item(rows[k].item, 0);
      if (rows[k].has_exp) begin
        if (pending_rects.size() != 1 || pending_rects[0] !== rows[k].exp) begin
          $display("%0t: directed row %0d expected %h actual %h", $time, k,
                   rows[k].exp, pending_rects.size() ? pending_rects[0] : '0);
          dir_errors++;
        end
      end
    end
    drain();

    // Store full: load past capacity, then run.
    write_player_kind(4'hF);
    for (int k = 0; k < CAP + 3; k++) send_item(rand_load(), 1);
    send_item(run_item(), 1);
    drain();

    // Random phases under varying player kinds. The entry count persists,
    // so loads past capacity keep being dropped.
    runs = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_player_kind(ph == 0 ? 4'h0 : (ph == 5 ? 4'hF : 4'($urandom_range(0, 2))));
      repeat (40) begin
        if ($urandom_range(0, 5) == 0) begin
          send_item(run_item(), 1);
          runs++;
          if (runs % 4 == 0) drain();
        end else begin
          send_item(rand_load(), 1);
        end
      end
      send_item(run_item(), 1);
      drain();
    end

    stop_idle = 1;
    drain();
    if (errors == 0 && dir_errors == 0 && pending_rects.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/aabbcr_pkg.sv
hdl/aabbcr_ram.sv
hdl/aabbcr_ctrl.sv
hdl/aabbcr_dpath.sv
hdl/aabb_pairwise_collision_resolve_unit.sv
tb/testbench.sv
